### rtl/vlrrf_pkg.sv
`default_nettype none

package vlrrf_pkg;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;

  // Command codes carried on in_tuser.
  localparam cmd_t CMD_PUSH_START = 3'd0;
  localparam cmd_t CMD_PUSH_BYTE  = 3'd1;
  localparam cmd_t CMD_POP        = 3'd2;
  localparam cmd_t CMD_PEEK       = 3'd3;
  localparam cmd_t CMD_CLEAR      = 3'd4;

  // Result status codes carried on out_tuser.
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_REJECTED = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;

  // Width of record lengths, read limits and byte counts within one record.
  localparam int LEN_W = 7;

endpackage

`default_nettype wire

### rtl/variable_length_record_ring_fifo_unit.sv
`default_nettype none

// Byte ring FIFO of QUEUE_BYTES bytes that stores variable-length records, each
// preceded by a HEADER_BYTES length header (least significant byte first). One
// command word goes in per accepted input handshake; in_tuser holds the command
// (push start, push byte, pop, peek, clear). Push start reserves header plus body
// or rejects the record when it is longer than MAX_RECORD or does not fit the free
// space; push bytes then fill the body in order. Pop and peek return up to
// read_limit bytes of the oldest record, one output word per byte, with tlast on
// the final word; pop also frees the whole record. Every other command returns
// exactly one output word. All storage goes through one ring memory with a single
// write port and a single read port whose data is registered, driven by a small
// sequencer. Push byte, clear and a rejected push start finish at once; an
// accepted push start then writes any further header bytes, one header byte
// written per cycle. A pop or peek of a non-empty queue first reads and sizes
// the header, then reads each delivered byte and loads it into the output
// register, or sends one word with no byte when none is delivered; an empty
// queue answers at once. Stalls on the output side hold up the sequencer and the
// input. The store needs no clearing after reset: the queue bookkeeping alone
// decides which entries hold data.
module variable_length_record_ring_fifo_unit #(
  parameter int QUEUE_BYTES  = 256,
  parameter int HEADER_BYTES = 1,
  parameter int MAX_RECORD   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // Fields from bit 0 up: data_byte[7:0], record_length[14:8],
  // read_limit[21:15], zero fill [23:22].
  input  wire logic [23:0] in_tdata,
  // Fields from bit 0 up: command[2:0].
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // Fields from bit 0 up: out_byte[7:0].
  output logic [7:0]       out_tdata,
  // Fields from bit 0 up: status[1:0], has_data[2].
  output logic [2:0]       out_tuser,
  output logic             out_tlast
);

  localparam int IDX_W  = $clog2(QUEUE_BYTES);
  localparam int FREE_W = $clog2(QUEUE_BYTES + 1);
  localparam int SUM_W  = ((FREE_W > 8) ? FREE_W : 8) + 1;
  localparam int LEN_W  = vlrrf_pkg::LEN_W;

  localparam logic [SUM_W-1:0] Q_S   = SUM_W'(QUEUE_BYTES);
  localparam logic [SUM_W-1:0] HDR_S = SUM_W'(HEADER_BYTES);
  localparam logic [SUM_W-1:0] MAX_S = SUM_W'(MAX_RECORD);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_BYTES - 1);
  localparam logic [LEN_W-1:0] HDR_LAST = LEN_W'(HEADER_BYTES - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HWR   = 3'd1;  // write remaining header bytes
  localparam logic [2:0] S_HRD   = 3'd2;  // issue header byte read
  localparam logic [2:0] S_HCAP  = 3'd3;  // capture header byte
  localparam logic [2:0] S_CALC  = 3'd4;  // size the record, free it on pop
  localparam logic [2:0] S_EMIT0 = 3'd5;  // answer with no data bytes
  localparam logic [2:0] S_BRD   = 3'd6;  // issue body byte read
  localparam logic [2:0] S_BEMIT = 3'd7;  // hand body byte to the output

  // Unpacked input fields.
  vlrrf_pkg::cmd_t   in_cmd;
  logic [7:0]        in_byte;
  logic [LEN_W-1:0]  in_len;
  logic [LEN_W-1:0]  in_limit;

  // Control registers.
  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              rej_r, rej_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers of a multi-cycle command.
  logic [IDX_W-1:0]  rp_r, rp_nxt;
  logic [IDX_W-1:0]  wp_r, wp_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  lim_r, lim_nxt;
  logic              rm_r, rm_nxt;
  logic [7:0]        lb_r, lb_nxt;
  logic              ov_r, ov_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt;

  // Output payload registers.
  vlrrf_pkg::status_t out_status_r, out_status_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_has_r, out_has_nxt;
  logic               out_last_r, out_last_nxt;

  // Ring memory ports.
  logic [7:0]        mem [QUEUE_BYTES];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [7:0]        rdata_r;

  // Datapath helpers.
  logic              out_load;
  logic              accept;
  logic [SUM_W-1:0]  need_s;
  logic              push_reject;
  logic [SUM_W-1:0]  used_s;
  logic [SUM_W-1:0]  body_s;
  logic [SUM_W-1:0]  cand_s;
  logic [SUM_W-1:0]  len_s;
  logic [SUM_W-1:0]  span_s;
  logic [LEN_W-1:0]  n_calc;
  logic [IDX_W-1:0]  rp_inc;
  logic [IDX_W-1:0]  wp_inc;

  function automatic logic [IDX_W-1:0] wrap_f(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] d;
    d = s - Q_S;
    return (s >= Q_S) ? d[IDX_W-1:0] : s[IDX_W-1:0];
  endfunction

  assign in_cmd   = vlrrf_pkg::cmd_t'(in_tuser);
  assign in_byte  = in_tdata[7:0];
  assign in_len   = in_tdata[14:8];
  assign in_limit = in_tdata[21:15];

  // The output register can take a new word when it is empty or being drained.
  assign out_load  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_load;
  assign accept    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_has_r, out_status_r};
  assign out_tlast  = out_last_r;

  assign rp_inc = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
  assign wp_inc = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;

  // Push start admission: the body must not exceed MAX_RECORD and header plus body must fit the free space.
  assign need_s      = HDR_S + SUM_W'(in_len);
  assign push_reject = (SUM_W'(in_len) > MAX_S) || (need_s > SUM_W'(free_r));

  // Record sizing after the header has been read. The stored length is clamped
  // to what the queue holds and to the longest legal record.
  assign used_s = Q_S - SUM_W'(free_r);
  assign body_s = (used_s > HDR_S) ? used_s - HDR_S : '0;
  assign cand_s = (ov_r || (SUM_W'(lb_r) > MAX_S)) ? MAX_S : SUM_W'(lb_r);
  assign len_s  = (cand_s > body_s) ? body_s : cand_s;
  assign span_s = ((HDR_S + len_s) > used_s) ? used_s : HDR_S + len_s;
  assign n_calc = (SUM_W'(lim_r) < len_s) ? lim_r : len_s[LEN_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    rem_nxt        = rem_r;
    rej_nxt        = rej_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    cnt_nxt        = cnt_r;
    lim_nxt        = lim_r;
    rm_nxt         = rm_r;
    lb_nxt         = lb_r;
    ov_nxt         = ov_r;
    n_nxt          = n_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = tail_r;
    mem_wdata      = {1'b0, in_len};
    mem_re         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Most commands answer at once with one status word.
          out_valid_nxt  = 1'b1;
          out_status_nxt = vlrrf_pkg::ST_OK;
          out_byte_nxt   = '0;
          out_has_nxt    = 1'b0;
          out_last_nxt   = 1'b1;
          unique case (in_cmd)
            vlrrf_pkg::CMD_PUSH_START: begin
              if (push_reject) begin
                rej_nxt        = 1'b1;
                rem_nxt        = '0;
                out_status_nxt = vlrrf_pkg::ST_REJECTED;
              end else begin
                // The low header byte holds the whole length; any further
                // header bytes are zero and are written in the cycles after.
                mem_we    = 1'b1;
                mem_waddr = tail_r;
                mem_wdata = {1'b0, in_len};
                tail_nxt  = wrap_f(SUM_W'(tail_r) + need_s);
                free_nxt  = FREE_W'(SUM_W'(free_r) - need_s);
                rem_nxt   = in_len;
                rej_nxt   = 1'b0;
                if (HEADER_BYTES > 1) begin
                  wp_nxt    = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
                  cnt_nxt   = LEN_W'(1);
                  state_nxt = S_HWR;
                end
              end
            end
            vlrrf_pkg::CMD_PUSH_BYTE: begin
              if (rej_r) begin
                out_status_nxt = vlrrf_pkg::ST_REJECTED;
              end else if (rem_r != '0) begin
                // Body bytes land behind the tail, which already points past
                // the reserved space.
                mem_we    = 1'b1;
                mem_waddr = wrap_f(SUM_W'(tail_r) + Q_S - SUM_W'(rem_r));
                mem_wdata = in_byte;
                rem_nxt   = rem_r - 1'b1;
              end
            end
            vlrrf_pkg::CMD_POP, vlrrf_pkg::CMD_PEEK: begin
              if (free_r == FREE_W'(QUEUE_BYTES)) begin
                out_status_nxt = vlrrf_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = out_valid_r && !out_tready;
                rp_nxt        = head_r;
                cnt_nxt       = '0;
                lim_nxt       = in_limit;
                rm_nxt        = (in_cmd == vlrrf_pkg::CMD_POP);
                lb_nxt        = '0;
                ov_nxt        = 1'b0;
                state_nxt     = S_HRD;
              end
            end
            vlrrf_pkg::CMD_CLEAR: begin
              head_nxt = '0;
              tail_nxt = '0;
              free_nxt = FREE_W'(QUEUE_BYTES);
              rem_nxt  = '0;
              rej_nxt  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_HWR: begin
        mem_we    = 1'b1;
        mem_waddr = wp_r;
        mem_wdata = '0;
        wp_nxt    = wp_inc;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == HDR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_HRD: begin
        mem_re    = 1'b1;
        rp_nxt    = rp_inc;
        state_nxt = S_HCAP;
      end
      S_HCAP: begin
        // Only the low header byte can carry a legal length; a nonzero higher
        // byte marks the length as oversized.
        if (cnt_r == '0) begin
          lb_nxt = rdata_r;
        end else if (rdata_r != '0) begin
          ov_nxt = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r == HDR_LAST) ? S_CALC : S_HRD;
      end
      S_CALC: begin
        n_nxt   = n_calc;
        cnt_nxt = '0;
        if (rm_r) begin
          head_nxt = wrap_f(SUM_W'(head_r) + span_s);
          free_nxt = FREE_W'(SUM_W'(free_r) + span_s);
        end
        state_nxt = (n_calc == '0) ? S_EMIT0 : S_BRD;
      end
      S_EMIT0: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = vlrrf_pkg::ST_OK;
          out_byte_nxt   = '0;
          out_has_nxt    = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_BRD: begin
        mem_re    = 1'b1;
        rp_nxt    = rp_inc;
        state_nxt = S_BEMIT;
      end
      S_BEMIT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = vlrrf_pkg::ST_OK;
          out_byte_nxt   = rdata_r;
          out_has_nxt    = 1'b1;
          out_last_nxt   = (cnt_r + 1'b1 == n_r);
          cnt_nxt        = cnt_r + 1'b1;
          state_nxt      = (cnt_r + 1'b1 == n_r) ? S_IDLE : S_BRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Ring memory: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= FREE_W'(QUEUE_BYTES);
      rem_r       <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      rem_r       <= rem_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r         <= rp_nxt;
    wp_r         <= wp_nxt;
    cnt_r        <= cnt_nxt;
    lim_r        <= lim_nxt;
    rm_r         <= rm_nxt;
    lb_r         <= lb_nxt;
    ov_r         <= ov_nxt;
    n_r          <= n_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_has_r    <= out_has_nxt;
    out_last_r   <= out_last_nxt;
  end

  // The free count never exceeds the ring size.
  assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FREE_W'(QUEUE_BYTES))
    else $error("free byte count exceeds ring size");

  // Head and tail always index inside the ring.
  assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= LAST_IDX) && (tail_r <= LAST_IDX))
    else $error("ring index out of range");

  // An open push never expects more body bytes than the longest record.
  assert property (@(posedge clk) disable iff (!rst_n)
    SUM_W'(rem_r) <= MAX_S)
    else $error("push remaining count exceeds record limit");

  // Body delivery only runs with a nonzero byte count and stops at it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BEMIT) |-> ((n_r != '0) && (cnt_r < n_r)))
    else $error("body byte count out of range");

endmodule

`default_nettype wire

### test/variable_length_record_ring_fifo_checker.sv
`timescale 1ns / 100ps

// Watches both streams of the record FIFO. It keeps its own copy of the ring
// and its bookkeeping, predicts the words that each accepted command causes,
// and compares every delivered word with the oldest prediction.
module variable_length_record_ring_fifo_checker #(
  parameter int QUEUE_BYTES  = 256,
  parameter int HEADER_BYTES = 1,
  parameter int MAX_RECORD   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_words,
  output int          readable_bytes
);

  localparam int PTR_W  = $clog2(QUEUE_BYTES);
  localparam int FREE_W = PTR_W + 1;
  localparam int LEN_W  = vlrrf_pkg::LEN_W;
  // Reported when a pop or peek of any limit only touches written entries.
  localparam int ANY_LIMIT = 127;

  typedef struct packed {
    vlrrf_pkg::status_t status;
    logic [7:0]         data;
    logic               has_data;
    logic               last;
  } result_word_t;

  result_word_t      expected_words[$];
  logic [7:0]        ring_bytes [QUEUE_BYTES];
  bit                ever_written [QUEUE_BYTES];
  logic [PTR_W-1:0]  head_ptr;
  logic [PTR_W-1:0]  tail_ptr;
  logic [FREE_W-1:0] free_count;
  logic [LEN_W-1:0]  body_left;
  logic              push_dropped;

  int mismatches = 0;
  int queued     = 0;
  int readable   = ANY_LIMIT;

  assign fail_count     = mismatches;
  assign pending_words  = queued;
  assign readable_bytes = readable;

  function automatic int wrap(int base, int k);
    return (base + k) % QUEUE_BYTES;
  endfunction

  task automatic queue_word(vlrrf_pkg::status_t st, logic [7:0] d, logic h, logic l);
    result_word_t w;
    w.status   = st;
    w.data     = d;
    w.has_data = h;
    w.last     = l;
    expected_words.push_back(w);
  endtask

  task automatic empty_queue();
    head_ptr     = '0;
    tail_ptr     = '0;
    free_count   = FREE_W'(QUEUE_BYTES);
    body_left    = '0;
    push_dropped = 1'b0;
  endtask

  // Length of the oldest record, capped by what is stored and by MAX_RECORD.
  function automatic int front_length();
    longint len;
    int     used;
    int     body;
    len = 0;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (i < 8) len |= longint'(ring_bytes[wrap(head_ptr, i)]) << (8 * i);
    end
    used = QUEUE_BYTES - free_count;
    body = used > HEADER_BYTES ? used - HEADER_BYTES : 0;
    if (len > body) len = body;
    if (len > MAX_RECORD) len = MAX_RECORD;
    return int'(len);
  endfunction

  // How many front bytes may be read before an entry that was never written.
  function automatic int safe_front_bytes();
    int len;
    int k;
    if (free_count >= QUEUE_BYTES) return ANY_LIMIT;
    len = front_length();
    k = 0;
    while (k < len && ever_written[wrap(head_ptr, HEADER_BYTES + k)]) k++;
    return (k == len) ? ANY_LIMIT : k;
  endfunction

  task automatic deliver_front(int limit, bit remove);
    int len;
    int n;
    int used;
    int span;
    if (free_count >= QUEUE_BYTES) begin
      queue_word(vlrrf_pkg::ST_EMPTY, 8'h00, 1'b0, 1'b1);
      return;
    end
    len = front_length();
    used = QUEUE_BYTES - free_count;
    n = (limit < len) ? limit : len;
    if (n == 0) begin
      queue_word(vlrrf_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) begin
        queue_word(vlrrf_pkg::ST_OK, ring_bytes[wrap(head_ptr, HEADER_BYTES + i)],
                   1'b1, i + 1 == n);
      end
    end
    if (remove) begin
      span = HEADER_BYTES + len;
      if (span > used) span = used;
      head_ptr   = PTR_W'(wrap(head_ptr, span));
      free_count = FREE_W'(int'(free_count) + span);
    end
  endtask

  task automatic model_command(vlrrf_pkg::cmd_t cmd, logic [7:0] data,
                               logic [6:0] rec_len, logic [6:0] limit);
    int pos;
    unique case (cmd)
      vlrrf_pkg::CMD_PUSH_START: begin
        if (rec_len > MAX_RECORD ||
            HEADER_BYTES + int'(rec_len) > int'(free_count)) begin
          push_dropped = 1'b1;
          body_left    = '0;
          queue_word(vlrrf_pkg::ST_REJECTED, 8'h00, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < HEADER_BYTES; i++) begin
            pos = wrap(tail_ptr, i);
            ring_bytes[pos]   = (i < 8) ? 8'((int'(rec_len) >> (8 * i)) & 8'hFF) : 8'h00;
            ever_written[pos] = 1'b1;
          end
          tail_ptr     = PTR_W'(wrap(tail_ptr, HEADER_BYTES + int'(rec_len)));
          free_count   = FREE_W'(int'(free_count) - (HEADER_BYTES + int'(rec_len)));
          body_left    = rec_len;
          push_dropped = 1'b0;
          queue_word(vlrrf_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
        end
      end
      vlrrf_pkg::CMD_PUSH_BYTE: begin
        if (push_dropped) begin
          queue_word(vlrrf_pkg::ST_REJECTED, 8'h00, 1'b0, 1'b1);
        end else begin
          if (body_left > 0) begin
            pos = wrap(tail_ptr, QUEUE_BYTES - int'(body_left));
            ring_bytes[pos]   = data;
            ever_written[pos] = 1'b1;
            body_left         = body_left - 1'b1;
          end
          queue_word(vlrrf_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
        end
      end
      vlrrf_pkg::CMD_POP:  deliver_front(int'(limit), 1'b1);
      vlrrf_pkg::CMD_PEEK: deliver_front(int'(limit), 1'b0);
      vlrrf_pkg::CMD_CLEAR: begin
        empty_queue();
        queue_word(vlrrf_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
      end
      default: queue_word(vlrrf_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin : monitor
    result_word_t want;
    result_word_t got;
    if (!rst_n) begin
      empty_queue();
      expected_words.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        model_command(in_tuser, in_tdata[7:0], in_tdata[14:8], in_tdata[21:15]);
      end
      if (out_tvalid && out_tready) begin
        got.status   = out_tuser[1:0];
        got.has_data = out_tuser[2];
        got.data     = out_tdata;
        got.last     = out_tlast;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: status %0d byte %02h has_data %0b last %0b",
                   $time, got.status, got.data, got.has_data, got.last);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status || got.data !== want.data ||
              got.has_data !== want.has_data || got.last !== want.last) begin
            $display("%0t: mismatch: expected status %0d byte %02h has_data %0b last %0b",
                     $time, want.status, want.data, want.has_data, want.last);
            $display("%0t:           actual   status %0d byte %02h has_data %0b last %0b",
                     $time, got.status, got.data, got.has_data, got.last);
            mismatches++;
          end
        end
      end
    end
    queued   = expected_words.size();
    readable = safe_front_bytes();
  end

endmodule

### test/variable_length_record_ring_fifo_unit_test.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the record FIFO. The checker beside the block does
// all prediction and comparison; this module only decides which command words
// go in, paces both streams and reads the checker's counts, among them the failure count at the end.
module variable_length_record_ring_fifo_unit_test;

  // Command codes the block does not define; it must answer them with one
  // plain ok word.
  localparam vlrrf_pkg::cmd_t CMD_UNUSED_LO = 3'd5;
  localparam vlrrf_pkg::cmd_t CMD_UNUSED_HI = 3'd7;

  // The longest correct quiet stretch is the deliberate output hold-off, so
  // the watchdog allows several times that before it gives up.
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  // After the last expected word the bench waits longer than a pop of a full-size
  // record takes, so that a stray extra word is still caught.
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_GAP      = 19;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = vlrrf_pkg::CMD_PUSH_START;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int pending_words;
  int readable_bytes;

  // Set by the stimulus process; the pacing processes read no_idle and
  // hold_output at falling edges, so the handoff never races.
  bit no_idle     = 1'b0;
  bit hold_output = 1'b0;
  int words_sent  = 0;

  always #4 clk = ~clk;

  variable_length_record_ring_fifo_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  variable_length_record_ring_fifo_checker checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending_words  (pending_words),
    .readable_bytes (readable_bytes)
  );

  // Offers one command word and returns at the rising edge that accepts it.
  // A pop or peek limit is cut back only when it reaches body bytes of the front
  // record whose entries were never written; reading those would return undefined
  // memory, so the checker reports how far the front can safely be read.
  task automatic send_word(input vlrrf_pkg::cmd_t cmd, input logic [7:0] data,
                           input logic [6:0] rec_len, input logic [6:0] limit);
    int         gap;
    logic [6:0] lim;
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    lim = limit;
    if ((cmd == vlrrf_pkg::CMD_POP || cmd == vlrrf_pkg::CMD_PEEK) &&
        int'(lim) > readable_bytes) begin
      lim = 7'($urandom_range(readable_bytes, 0));
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, lim, rec_len, data};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // Stops offering words until the checker holds no more expectations.
  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  // Mostly short records, some near or at the largest size, a few too long.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99, 0);
    if (r < 65) return $urandom_range(10, 0);
    if (r < 85) return $urandom_range(63, 11);
    if (r < 93) return 64;
    return $urandom_range(127, 65);
  endfunction

  function automatic int pick_limit();
    int r;
    r = $urandom_range(99, 0);
    if (r < 50) return $urandom_range(12, 0);
    if (r < 80) return $urandom_range(64, 13);
    return $urandom_range(127, 65);
  endfunction

  // The directed part walks through every command and the corner cases:
  // empty queue on pop and peek, a zero-length record, an over-long record
  // and the bytes that follow it, bytes past the declared length, a byte
  // with no record open, a push start that abandons an unfinished body, a
  // queue too full for the next record, an undefined command and clear.
  task automatic directed_checks();
    send_word(vlrrf_pkg::CMD_POP,        8'h3C, 7'd17,  7'd64);
    send_word(vlrrf_pkg::CMD_PEEK,       8'hC3, 7'd99,  7'd127);
    send_word(vlrrf_pkg::CMD_PUSH_START, 8'hFF, 7'd0,   7'd0);
    send_word(vlrrf_pkg::CMD_PEEK,       8'h00, 7'd127, 7'd5);
    send_word(vlrrf_pkg::CMD_POP,        8'h11, 7'd1,   7'd0);
    send_word(vlrrf_pkg::CMD_PUSH_START, 8'h00, 7'd65,  7'd127);
    send_word(vlrrf_pkg::CMD_PUSH_BYTE,  8'h77, 7'd3,   7'd3);
    send_word(vlrrf_pkg::CMD_PUSH_START, 8'h00, 7'd3,   7'd0);
    send_word(vlrrf_pkg::CMD_PUSH_BYTE,  8'h00, 7'd0,   7'd0);
    send_word(vlrrf_pkg::CMD_PUSH_BYTE,  8'hFF, 7'd127, 7'd127);
    send_word(vlrrf_pkg::CMD_PUSH_BYTE,  8'hA5, 7'd42,  7'd21);
    send_word(vlrrf_pkg::CMD_PUSH_BYTE,  8'h5A, 7'd64,  7'd64);
    send_word(vlrrf_pkg::CMD_PEEK,       8'h00, 7'd0,   7'd127);
    send_word(vlrrf_pkg::CMD_POP,        8'h00, 7'd0,   7'd2);
    send_word(vlrrf_pkg::CMD_PUSH_BYTE,  8'h99, 7'd5,   7'd9);
    send_word(vlrrf_pkg::CMD_PUSH_START, 8'h00, 7'd4,   7'd0);
    send_word(vlrrf_pkg::CMD_PUSH_BYTE,  8'h12, 7'd0,   7'd0);
    send_word(vlrrf_pkg::CMD_PUSH_BYTE,  8'h34, 7'd0,   7'd0);
    send_word(vlrrf_pkg::CMD_PUSH_START, 8'h00, 7'd2,   7'd0);
    send_word(vlrrf_pkg::CMD_PUSH_BYTE,  8'h56, 7'd0,   7'd0);
    send_word(vlrrf_pkg::CMD_PUSH_BYTE,  8'h78, 7'd0,   7'd0);
    send_word(vlrrf_pkg::CMD_POP,        8'h00, 7'd0,   7'd64);
    send_word(vlrrf_pkg::CMD_POP,        8'h00, 7'd0,   7'd127);
    // Three full-size reservations fit; the fourth finds no room.
    repeat (4) send_word(vlrrf_pkg::CMD_PUSH_START, 8'h00, 7'd64, 7'd0);
    send_word(CMD_UNUSED_HI,             8'hFF, 7'd127, 7'd127);
    send_word(vlrrf_pkg::CMD_CLEAR,      8'hFF, 7'd127, 7'd127);
  endtask

  // Random traffic, mostly whole records with random content. The rest is
  // pops, peeks, clears, undefined commands, stray bytes and records with
  // too few or too many bytes.
  task automatic random_burst(input int count);
    int target;
    int pick;
    int len;
    int n_bytes;
    target = words_sent + count;
    while (words_sent < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
        len = pick_length();
        send_word(vlrrf_pkg::CMD_PUSH_START, 8'($urandom_range(255, 0)), 7'(len),
                  7'($urandom_range(127, 0)));
        if (len > 64) begin
          n_bytes = $urandom_range(3, 0);
        end else begin
          pick = $urandom_range(99, 0);
          if (pick < 85) n_bytes = len;
          else if (pick < 95) n_bytes = $urandom_range(len, 0);
          else n_bytes = len + $urandom_range(2, 1);
        end
        repeat (n_bytes) begin
          send_word(vlrrf_pkg::CMD_PUSH_BYTE, 8'($urandom_range(255, 0)),
                    7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)));
        end
      end else if (pick < 75) begin
        send_word(vlrrf_pkg::CMD_POP, 8'($urandom_range(255, 0)),
                  7'($urandom_range(127, 0)), 7'(pick_limit()));
      end else if (pick < 88) begin
        send_word(vlrrf_pkg::CMD_PEEK, 8'($urandom_range(255, 0)),
                  7'($urandom_range(127, 0)), 7'(pick_limit()));
      end else if (pick < 92) begin
        send_word(vlrrf_pkg::CMD_CLEAR, 8'($urandom_range(255, 0)),
                  7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)));
      end else if (pick < 96) begin
        send_word(3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)),
                  8'($urandom_range(255, 0)),
                  7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)));
      end else begin
        send_word(vlrrf_pkg::CMD_PUSH_BYTE, 8'($urandom_range(255, 0)),
                  7'($urandom_range(127, 0)), 7'($urandom_range(127, 0)));
      end
    end
  endtask

  // Result side: before each word it draws a stall, except when asked for a
  // long hold-off, which it counts out itself while the sender keeps going.
  initial begin : result_pacing
    int stall;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Ends the run when neither stream has moved a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    directed_checks();
    random_burst(150);
    // Let all expected words come out before carrying on.
    wait_for_drain();
    // A stretch where neither side idles at all.
    no_idle = 1'b1;
    random_burst(50);
    no_idle = 1'b0;
    // The result side stops taking words for a long time while commands keep
    // coming, so the block backs up and stalls its input.
    hold_output = 1'b1;
    random_burst(30);
    random_burst(70);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/vlrrf_pkg.sv
rtl/variable_length_record_ring_fifo_unit.sv
test/variable_length_record_ring_fifo_checker.sv
test/variable_length_record_ring_fifo_unit_test.sv
